// ===== rtl/core/stq_pkg.sv =====
// Shared types and codes for the sorted timer queue.
// Depends on nothing; used by stq_mem and sorted_timer_queue.
package stq_pkg;

  localparam int TIMER_SLOTS = 16;
  localparam int TIME_BITS   = 32;
  localparam int TAG_BITS    = 16;
  localparam int HANDLE_BITS = $clog2(TIMER_SLOTS);
  localparam int COUNT_BITS  = $clog2(TIMER_SLOTS + 1);

  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;

  localparam logic [1:0] KIND_ABS      = 2'd0;
  localparam logic [1:0] KIND_ONESHOT  = 2'd1;
  localparam logic [1:0] KIND_PERIODIC = 2'd2;

  localparam logic [2:0] ST_ADDED     = 3'd0;
  localparam logic [2:0] ST_REMOVED   = 3'd1;
  localparam logic [2:0] ST_FIRED     = 3'd2;
  localparam logic [2:0] ST_NONE_DUE  = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_PAST      = 3'd5;
  localparam logic [2:0] ST_NOT_FOUND = 3'd6;
  localparam logic [2:0] ST_ZERO_PER  = 3'd7;

  typedef struct packed {
    logic [1:0]             req_type;
    logic [1:0]             timer_kind;
    logic [TIME_BITS-1:0]   delay;
    logic [TAG_BITS-1:0]    tag;
    logic [HANDLE_BITS-1:0] handle;
    logic [TIME_BITS-1:0]   now;
  } req_t;

  typedef struct packed {
    logic [2:0]             status;
    logic [HANDLE_BITS-1:0] handle_res;
    logic [TAG_BITS-1:0]    tag_res;
    logic [1:0]             timer_kind_res;
    logic [TIME_BITS-1:0]   expire_time;
    logic                   last;
  } res_t;

  typedef struct packed {
    logic [TIME_BITS-1:0]   expire;
    logic [TIME_BITS-1:0]   delay;
    logic [1:0]             kind;
    logic [TAG_BITS-1:0]    tag;
    logic [HANDLE_BITS-1:0] handle;
  } entry_t;

endpackage

// ===== rtl/core/stq_mem.sv =====
// Slot memory of the timer queue: one write port, one read port, registered read.
// Depends on stq_pkg for the entry type and depth.
module stq_mem (
  input  logic                            clk,
  input  logic                            we,
  input  logic [stq_pkg::HANDLE_BITS-1:0] waddr,
  input  stq_pkg::entry_t                 wdata,
  input  logic [stq_pkg::HANDLE_BITS-1:0] raddr,
  output stq_pkg::entry_t                 rdata
);
  import stq_pkg::*;

  entry_t mem [TIMER_SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/sorted_timer_queue.sv =====
// Top level of the sorted timer queue: request sequencer around the slot memory.
// Depends on stq_pkg and stq_mem.
//
//  channel   | direction | handshake                     | payload
//  request   | in        | start high while busy is low  | request (req_t)
//  result    | out       | valid high for one cycle      | result (res_t)
//
// A request that reaches the slot memory walks it one entry at a time. Each
// memory visit has a read state, which issues the read, and a compare or write
// state, which uses the registered data. An add moves every entry with a later
// expiry up one slot, from the tail, and then writes the new one. A remove
// searches by handle from the head and then pulls every entry after it down one
// slot. A tick checks the head until it is not due or the queue is empty; each
// fired timer adds a delete pass and, when re-armed, an insert pass as for an add.
// Reset clears the entry count, the handle flags and the current time; the
// slot memory keeps whatever it holds, since only slots below the count are
// read. Results cannot be stalled: each transfer is one valid cycle.
module sorted_timer_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  stq_pkg::req_t   request,
  output logic            valid,
  output stq_pkg::res_t   result
);
  import stq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_INS, S_INS_CMP, S_RM_RD, S_RM_CMP, S_DEL, S_DEL_WR, S_TK_RD, S_TK_CMP
  } state_t;

  state_t                 state;
  logic [1:0]             op;
  logic [HANDLE_BITS-1:0] hin;
  logic [COUNT_BITS-1:0]  cnt;
  logic [COUNT_BITS-1:0]  idx;
  logic [TIMER_SLOTS-1:0] hbusy;
  logic [TIME_BITS-1:0]   cur_time;
  entry_t                 ins;
  logic                   rearm;
  logic                   pend_valid;
  res_t                   pend;

  // Memory port controls, driven from the sequencer.
  logic                   we;
  logic [HANDLE_BITS-1:0] waddr;
  logic [HANDLE_BITS-1:0] raddr;
  entry_t                 wdata;
  entry_t                 rdata;

  stq_mem u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Lowest free handle.
  logic [HANDLE_BITS-1:0] free_h;
  logic                   free_ok;
  always_comb begin
    free_h  = '0;
    free_ok = 1'b0;
    for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
      if (!hbusy[i]) begin
        free_h  = HANDLE_BITS'(i);
        free_ok = 1'b1;
      end
    end
  end

  // Add decode, evaluated against the incoming request.
  logic [1:0]           add_kind;
  logic [TIME_BITS:0]   add_sum;
  logic [TIME_BITS-1:0] add_ex;
  assign add_kind = (request.timer_kind == 2'd3) ? KIND_ABS : request.timer_kind;
  assign add_sum  = {1'b0, cur_time} + {1'b0, request.delay};
  assign add_ex   = (add_kind == KIND_ABS) ? request.delay : add_sum[TIME_BITS-1:0];

  // Re-arm time of the head entry during a tick.
  logic [TIME_BITS:0] rearm_sum;
  assign rearm_sum = {1'b0, cur_time} + {1'b0, rdata.delay};

  // A periodic head entry is re-armed unless its delay is zero or the new
  // expiry wraps; otherwise it is freed and reported as a one-shot.
  logic head_rearm;
  assign head_rearm = (rdata.kind == KIND_PERIODIC) && (rdata.delay != '0) &&
                      !rearm_sum[TIME_BITS];

  // Memory port muxing by state.
  always_comb begin
    we    = 1'b0;
    waddr = idx[HANDLE_BITS-1:0];
    wdata = ins;
    raddr = idx[HANDLE_BITS-1:0];
    case (state)
      S_INS: begin
        we    = (idx == '0);
        raddr = HANDLE_BITS'(idx - 1'b1);
      end
      S_INS_CMP: begin
        we    = 1'b1;
        wdata = (rdata.expire > ins.expire) ? rdata : ins;
      end
      S_DEL: begin
        raddr = HANDLE_BITS'(idx + 1'b1);
      end
      S_DEL_WR: begin
        we    = 1'b1;
        wdata = rdata;
      end
      S_TK_RD: begin
        raddr = '0;
      end
      default: begin
      end
    endcase
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      hbusy      <= '0;
      cur_time   <= '0;
      valid      <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            op     <= request.req_type;
            hin    <= request.handle;
            result <= '0;
            case (request.req_type)
              REQ_ADD: begin
                valid       <= 1'b1;
                result.last <= 1'b1;
                if (cnt == COUNT_BITS'(TIMER_SLOTS) || !free_ok) begin
                  result.status <= ST_FULL;
                end else if (add_kind == KIND_PERIODIC && request.delay == '0) begin
                  result.status <= ST_ZERO_PER;
                end else if (add_ex < cur_time) begin
                  result.status <= ST_PAST;
                end else begin
                  result.status         <= ST_ADDED;
                  result.handle_res     <= free_h;
                  result.tag_res        <= request.tag;
                  result.timer_kind_res <= add_kind;
                  result.expire_time    <= add_ex;
                  hbusy[free_h]         <= 1'b1;
                  ins <= '{expire: add_ex, delay: request.delay, kind: add_kind,
                           tag: request.tag, handle: free_h};
                  idx   <= cnt;
                  state <= S_INS;
                end
              end
              REQ_REMOVE: begin
                if (hbusy[request.handle]) begin
                  idx   <= '0;
                  state <= S_RM_RD;
                end else begin
                  valid             <= 1'b1;
                  result.status     <= ST_NOT_FOUND;
                  result.handle_res <= request.handle;
                  result.last       <= 1'b1;
                end
              end
              REQ_TICK: begin
                cur_time   <= request.now;
                pend_valid <= 1'b0;
                state      <= S_TK_RD;
              end
              default: begin
              end
            endcase
          end
        end

        // Insertion pass from the tail: move larger expiries up one slot.
        S_INS: begin
          if (idx == '0) begin
            cnt   <= cnt + 1'b1;
            state <= (op == REQ_TICK) ? S_TK_RD : S_IDLE;
          end else begin
            state <= S_INS_CMP;
          end
        end
        S_INS_CMP: begin
          if (rdata.expire > ins.expire) begin
            idx   <= idx - 1'b1;
            state <= S_INS;
          end else begin
            cnt   <= cnt + 1'b1;
            state <= (op == REQ_TICK) ? S_TK_RD : S_IDLE;
          end
        end

        // Search by handle.
        S_RM_RD: begin
          if (idx == cnt) begin
            hbusy[hin]        <= 1'b0;
            valid             <= 1'b1;
            result            <= '0;
            result.status     <= ST_NOT_FOUND;
            result.handle_res <= hin;
            result.last       <= 1'b1;
            state             <= S_IDLE;
          end else begin
            state <= S_RM_CMP;
          end
        end
        S_RM_CMP: begin
          if (rdata.handle == hin) begin
            hbusy[hin]            <= 1'b0;
            valid                 <= 1'b1;
            result.status         <= ST_REMOVED;
            result.handle_res     <= hin;
            result.tag_res        <= rdata.tag;
            result.timer_kind_res <= rdata.kind;
            result.expire_time    <= rdata.expire;
            result.last           <= 1'b1;
            state                 <= S_DEL;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_RM_RD;
          end
        end

        // Deletion pass: pull every later entry down one slot.
        S_DEL: begin
          if (idx + 1'b1 >= cnt) begin
            cnt <= cnt - 1'b1;
            if (op == REQ_TICK && rearm) begin
              idx   <= cnt - 1'b1;
              state <= S_INS;
            end else if (op == REQ_TICK) begin
              state <= S_TK_RD;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            state <= S_DEL_WR;
          end
        end
        S_DEL_WR: begin
          idx   <= idx + 1'b1;
          state <= S_DEL;
        end

        // Tick: look at the head; a fired result is held back one step so
        // that the final one can carry the last flag.
        S_TK_RD: begin
          if (cnt == '0) begin
            valid      <= 1'b1;
            pend_valid <= 1'b0;
            state      <= S_IDLE;
            if (pend_valid) begin
              result      <= pend;
              result.last <= 1'b1;
            end else begin
              result        <= '0;
              result.status <= ST_NONE_DUE;
              result.last   <= 1'b1;
            end
          end else begin
            state <= S_TK_CMP;
          end
        end
        S_TK_CMP: begin
          if (rdata.expire <= cur_time) begin
            if (pend_valid) begin
              valid  <= 1'b1;
              result <= pend;
            end
            pend_valid <= 1'b1;
            pend <= '{status: ST_FIRED, handle_res: rdata.handle, tag_res: rdata.tag,
                      timer_kind_res: (rdata.kind == KIND_PERIODIC && !head_rearm) ?
                                      KIND_ONESHOT : rdata.kind,
                      expire_time: rdata.expire, last: 1'b0};
            ins <= '{expire: rearm_sum[TIME_BITS-1:0], delay: rdata.delay,
                     kind: rdata.kind, tag: rdata.tag, handle: rdata.handle};
            rearm <= head_rearm;
            if (!head_rearm) begin
              hbusy[rdata.handle] <= 1'b0;
            end
            idx   <= '0;
            state <= S_DEL;
          end else begin
            valid      <= 1'b1;
            pend_valid <= 1'b0;
            state      <= S_IDLE;
            if (pend_valid) begin
              result      <= pend;
              result.last <= 1'b1;
            end else begin
              result        <= '0;
              result.status <= ST_NONE_DUE;
              result.last   <= 1'b1;
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
